// ===== src/ctsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types and constants of the clock time-set controller.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned CursorW = 2;
  localparam int unsigned DayW    = 17;
  localparam int unsigned RemW    = 12;

  localparam int unsigned DaySeconds    = 86400;
  localparam int unsigned HourSeconds   = 3600;
  localparam int unsigned MinuteSeconds = 60;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned MinutesPerHr  = 60;
  localparam int unsigned MaxHour       = 23;
  localparam int unsigned MaxMinute     = 59;

  localparam logic [TickW-1:0] TimeoutReset = 32'd30000;

  // count / 86400 == (count >> 7) / 675, reciprocal of 675 scaled by 2^35
  localparam int unsigned DayPreShift  = 7;
  localparam int unsigned DayRecipW    = 26;
  localparam logic [DayRecipW-1:0] DayRecip = 26'd50903316;
  localparam int unsigned DayRecipSh   = 35;

  // reciprocal of 3600 scaled by 2^30, of 60 scaled by 2^20
  localparam int unsigned HourRecipW   = 19;
  localparam logic [HourRecipW-1:0] HourRecip = 19'd298262;
  localparam int unsigned HourRecipSh  = 30;
  localparam int unsigned MinRecipW    = 15;
  localparam logic [MinRecipW-1:0] MinRecip = 15'd17477;
  localparam int unsigned MinRecipSh   = 20;

  localparam logic [CursorW-1:0] CursorNone   = 2'd0;
  localparam logic [CursorW-1:0] CursorHour   = 2'd1;
  localparam logic [CursorW-1:0] CursorMinute = 2'd2;

  typedef enum logic [11:0] {
    ST_WORK_ENTRY = 12'b0000_0000_0001,
    ST_WORK       = 12'b0000_0000_0010,
    ST_HOUR_ENTRY = 12'b0000_0000_0100,
    ST_HOUR_WAIT  = 12'b0000_0000_1000,
    ST_MIN_ENTRY  = 12'b0000_0001_0000,
    ST_MIN_WAIT   = 12'b0000_0010_0000,
    ST_HOUR_INC   = 12'b0000_0100_0000,
    ST_HOUR_DEC   = 12'b0000_1000_0000,
    ST_MIN_INC    = 12'b0001_0000_0000,
    ST_MIN_DEC    = 12'b0010_0000_0000,
    ST_UPDATE     = 12'b0100_0000_0000,
    ST_CANCEL     = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic [TickW-1:0]  tick_ms;
    logic [CountW-1:0] time_count;
    logic              press_set;
    logic              press_up;
    logic              press_down;
  } item_t;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } hms_t;

  typedef struct packed {
    logic               setup_mode;
    logic               show_valid;
    logic [HourW-1:0]   show_hour;
    logic [MinuteW-1:0] show_minute;
    logic [SecondW-1:0] show_second;
    logic [CursorW-1:0] cursor_field;
    logic               write_valid;
    logic [DayW-1:0]    write_seconds;
  } result_t;

endpackage

// ===== src/ctsc_day_rem.sv =====
// ----------------------------------------------------------------------------
// ctsc_day_rem
// Seconds count reduced modulo one day, by reciprocal multiply and one fixup.
// ----------------------------------------------------------------------------
module ctsc_day_rem (
  input  logic [ctsc_pkg::CountW-1:0] count_i,
  output logic [ctsc_pkg::DayW-1:0]   day_rem_o
);

  localparam int unsigned XW    = ctsc_pkg::CountW - ctsc_pkg::DayPreShift;
  localparam int unsigned ProdW = XW + ctsc_pkg::DayRecipW;
  localparam int unsigned QW    = ProdW - ctsc_pkg::DayRecipSh;

  logic [XW-1:0]                x;
  logic [ProdW-1:0]             prod;
  logic [QW-1:0]                q_est;
  logic [ctsc_pkg::CountW-1:0]  sub;
  logic [ctsc_pkg::DayW:0]      rem_raw;

  assign x     = count_i[ctsc_pkg::CountW-1:ctsc_pkg::DayPreShift];
  assign prod  = ProdW'(x) * ProdW'(ctsc_pkg::DayRecip);
  // estimate is the quotient or one below it
  assign q_est = prod[ProdW-1:ctsc_pkg::DayRecipSh];
  assign sub   = count_i - ctsc_pkg::CountW'(q_est) *
                 ctsc_pkg::CountW'(ctsc_pkg::DaySeconds);
  assign rem_raw = sub[ctsc_pkg::DayW:0];

  always_comb begin
    if (rem_raw >= (ctsc_pkg::DayW+1)'(ctsc_pkg::DaySeconds)) begin
      day_rem_o = ctsc_pkg::DayW'(rem_raw - (ctsc_pkg::DayW+1)'(ctsc_pkg::DaySeconds));
    end else begin
      day_rem_o = rem_raw[ctsc_pkg::DayW-1:0];
    end
  end

endmodule

// ===== src/ctsc_hms_split.sv =====
// ----------------------------------------------------------------------------
// ctsc_hms_split
// Seconds of the day split into hours, minutes and seconds.
// ----------------------------------------------------------------------------
module ctsc_hms_split (
  input  logic [ctsc_pkg::DayW-1:0] day_rem_i,
  output ctsc_pkg::hms_t            hms_o
);

  localparam int unsigned HProdW = ctsc_pkg::DayW + ctsc_pkg::HourRecipW;
  localparam int unsigned MProdW = ctsc_pkg::RemW + ctsc_pkg::MinRecipW;

  logic [HProdW-1:0]              h_prod;
  logic [ctsc_pkg::HourW-1:0]     hour;
  logic [ctsc_pkg::DayW-1:0]      hour_rem;
  logic [ctsc_pkg::RemW-1:0]      rem;
  logic [MProdW-1:0]              m_prod;
  logic [ctsc_pkg::MinuteW-1:0]   minute;
  logic [ctsc_pkg::RemW-1:0]      sec_full;

  assign h_prod   = HProdW'(day_rem_i) * HProdW'(ctsc_pkg::HourRecip);
  assign hour     = h_prod[ctsc_pkg::HourRecipSh +: ctsc_pkg::HourW];
  assign hour_rem = day_rem_i - ctsc_pkg::DayW'(hour) *
                    ctsc_pkg::DayW'(ctsc_pkg::HourSeconds);
  assign rem      = hour_rem[ctsc_pkg::RemW-1:0];

  assign m_prod   = MProdW'(rem) * MProdW'(ctsc_pkg::MinRecip);
  assign minute   = m_prod[ctsc_pkg::MinRecipSh +: ctsc_pkg::MinuteW];
  assign sec_full = rem - ctsc_pkg::RemW'(minute) *
                    ctsc_pkg::RemW'(ctsc_pkg::MinuteSeconds);

  assign hms_o.hour   = hour;
  assign hms_o.minute = minute;
  assign hms_o.second = sec_full[ctsc_pkg::SecondW-1:0];

endmodule

// ===== src/ctsc_fsm.sv =====
// ----------------------------------------------------------------------------
// ctsc_fsm
// Setup state machine: pending presses, edit values, display and write result.
// ----------------------------------------------------------------------------
module ctsc_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  ctsc_pkg::item_t            item_i,
  input  ctsc_pkg::hms_t             hms_i,
  input  logic [ctsc_pkg::TickW-1:0] timeout_i,
  output ctsc_pkg::result_t          result_o
);

  ctsc_pkg::state_e               state_q, state_d;
  logic [ctsc_pkg::TickW-1:0]     entry_tick_q, entry_tick_d;
  logic [ctsc_pkg::CountW-1:0]    last_count_q, last_count_d;
  logic [ctsc_pkg::HourW-1:0]     edit_hour_q, edit_hour_d;
  logic [ctsc_pkg::MinuteW-1:0]   edit_min_q, edit_min_d;
  logic                           pend_set_q, pend_set_d;
  logic                           pend_up_q, pend_up_d;
  logic                           pend_down_q, pend_down_d;
  logic                           mode_q, mode_d;

  logic                           p_set, p_up, p_down;
  logic [ctsc_pkg::TickW-1:0]     elapsed;
  logic                           expired;
  logic                           hour_phase;
  logic [ctsc_pkg::HourW:0]       hour_plus;
  logic [ctsc_pkg::MinuteW:0]     min_plus;
  logic [ctsc_pkg::DayW-1:0]      edit_seconds;

  assign p_set   = pend_set_q  | item_i.press_set;
  assign p_up    = pend_up_q   | item_i.press_up;
  assign p_down  = pend_down_q | item_i.press_down;
  // elapsed time wraps with the tick
  assign elapsed = item_i.tick_ms - entry_tick_q;
  assign expired = elapsed >= timeout_i;
  assign hour_phase = (state_q == ctsc_pkg::ST_HOUR_WAIT);
  assign hour_plus  = {1'b0, edit_hour_q} + 1'b1;
  assign min_plus   = {1'b0, edit_min_q} + 1'b1;
  assign edit_seconds =
    ctsc_pkg::DayW'(edit_hour_q) * ctsc_pkg::DayW'(ctsc_pkg::HourSeconds) +
    ctsc_pkg::DayW'(edit_min_q) * ctsc_pkg::DayW'(ctsc_pkg::MinuteSeconds);

  always_comb begin
    state_d      = state_q;
    entry_tick_d = entry_tick_q;
    last_count_d = last_count_q;
    edit_hour_d  = edit_hour_q;
    edit_min_d   = edit_min_q;
    pend_set_d   = pend_set_q;
    pend_up_d    = pend_up_q;
    pend_down_d  = pend_down_q;
    mode_d       = mode_q;
    result_o     = '0;

    if (step_i) begin
      pend_set_d  = p_set;
      pend_up_d   = p_up;
      pend_down_d = p_down;

      case (state_q)
        ctsc_pkg::ST_WORK_ENTRY, ctsc_pkg::ST_WORK: begin
          mode_d  = 1'b0;
          state_d = ctsc_pkg::ST_WORK;
          if (item_i.time_count != last_count_q) begin
            result_o.show_valid  = 1'b1;
            result_o.show_hour   = hms_i.hour;
            result_o.show_minute = hms_i.minute;
            result_o.show_second = hms_i.second;
            last_count_d         = item_i.time_count;
          end
          // entering setup drops any up or down waiting in work mode
          if (p_set) begin
            pend_set_d  = 1'b0;
            pend_up_d   = 1'b0;
            pend_down_d = 1'b0;
            edit_hour_d = hms_i.hour;
            edit_min_d  = hms_i.minute;
            state_d     = ctsc_pkg::ST_HOUR_ENTRY;
          end
        end
        ctsc_pkg::ST_HOUR_ENTRY, ctsc_pkg::ST_MIN_ENTRY: begin
          mode_d                = 1'b1;
          result_o.show_valid   = 1'b1;
          result_o.show_hour    = edit_hour_q;
          result_o.show_minute  = edit_min_q;
          entry_tick_d          = item_i.tick_ms;
          if (state_q == ctsc_pkg::ST_HOUR_ENTRY) begin
            result_o.cursor_field = ctsc_pkg::CursorHour;
            state_d               = ctsc_pkg::ST_HOUR_WAIT;
          end else begin
            result_o.cursor_field = ctsc_pkg::CursorMinute;
            state_d               = ctsc_pkg::ST_MIN_WAIT;
          end
        end
        ctsc_pkg::ST_HOUR_WAIT, ctsc_pkg::ST_MIN_WAIT: begin
          // a pending button beats the timeout
          if (expired) begin
            state_d = ctsc_pkg::ST_CANCEL;
          end
          if (p_set) begin
            pend_set_d = 1'b0;
            state_d    = hour_phase ? ctsc_pkg::ST_MIN_ENTRY : ctsc_pkg::ST_UPDATE;
          end else if (p_up) begin
            pend_up_d = 1'b0;
            state_d   = hour_phase ? ctsc_pkg::ST_HOUR_INC : ctsc_pkg::ST_MIN_INC;
          end else if (p_down) begin
            pend_down_d = 1'b0;
            state_d     = hour_phase ? ctsc_pkg::ST_HOUR_DEC : ctsc_pkg::ST_MIN_DEC;
          end
        end
        ctsc_pkg::ST_HOUR_INC: begin
          if (hour_plus >= (ctsc_pkg::HourW+1)'(ctsc_pkg::HoursPerDay)) begin
            edit_hour_d = '0;
          end else begin
            edit_hour_d = hour_plus[ctsc_pkg::HourW-1:0];
          end
          state_d = ctsc_pkg::ST_HOUR_ENTRY;
        end
        ctsc_pkg::ST_HOUR_DEC: begin
          if (edit_hour_q == '0 || edit_hour_q > ctsc_pkg::HourW'(ctsc_pkg::MaxHour)) begin
            edit_hour_d = ctsc_pkg::HourW'(ctsc_pkg::MaxHour);
          end else begin
            edit_hour_d = edit_hour_q - 1'b1;
          end
          state_d = ctsc_pkg::ST_HOUR_ENTRY;
        end
        ctsc_pkg::ST_MIN_INC: begin
          if (min_plus >= (ctsc_pkg::MinuteW+1)'(ctsc_pkg::MinutesPerHr)) begin
            edit_min_d = '0;
          end else begin
            edit_min_d = min_plus[ctsc_pkg::MinuteW-1:0];
          end
          state_d = ctsc_pkg::ST_MIN_ENTRY;
        end
        ctsc_pkg::ST_MIN_DEC: begin
          if (edit_min_q == '0 || edit_min_q > ctsc_pkg::MinuteW'(ctsc_pkg::MaxMinute)) begin
            edit_min_d = ctsc_pkg::MinuteW'(ctsc_pkg::MaxMinute);
          end else begin
            edit_min_d = edit_min_q - 1'b1;
          end
          state_d = ctsc_pkg::ST_MIN_ENTRY;
        end
        ctsc_pkg::ST_UPDATE: begin
          result_o.write_valid   = 1'b1;
          result_o.write_seconds = edit_seconds;
          state_d                = ctsc_pkg::ST_WORK_ENTRY;
        end
        default: begin
          state_d = ctsc_pkg::ST_WORK_ENTRY;
        end
      endcase

      result_o.setup_mode = mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ctsc_pkg::ST_WORK_ENTRY;
      entry_tick_q <= '0;
      last_count_q <= '0;
      edit_hour_q  <= '0;
      edit_min_q   <= '0;
      pend_set_q   <= 1'b0;
      pend_up_q    <= 1'b0;
      pend_down_q  <= 1'b0;
      mode_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      entry_tick_q <= entry_tick_d;
      last_count_q <= last_count_d;
      edit_hour_q  <= edit_hour_d;
      edit_min_q   <= edit_min_d;
      pend_set_q   <= pend_set_d;
      pend_up_q    <= pend_up_d;
      pend_down_q  <= pend_down_d;
      mode_q       <= mode_d;
    end
  end

endmodule

// ===== src/clock_time_set_controller.sv =====
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Polled clock time-set controller: one poll beat in, one result beat out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: tick, count, presses
//  m_axis    out  m_axis_tvalid/tready        tdata: mode, display, write
//  cfg       in   cfg_we_i (no stall)         cfg_wdata_i: setup timeout ms
//
//  one beat per cycle sustained while m_axis_tready holds; a result beat is
//  offered via the input register, then state machine into result register
//  reset clears the valid flags and the state machine but not the data
//  registers; timeout returns to 30000 ms; a stalled result register holds its
//  beat while one more poll waits in the input register
// ----------------------------------------------------------------------------
module clock_time_set_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] tick_ms, [63:32] time_count, [64] press_set, [65] press_up,
  // [66] press_down, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] setup_mode, [1] show_valid, [6:2] show_hour, [12:7] show_minute,
  // [18:13] show_second, [20:19] cursor_field, [21] write_valid,
  // [38:22] write_seconds, [39] zero
  output logic [39:0] m_axis_tdata
);

  logic [ctsc_pkg::TickW-1:0] timeout_q;

  ctsc_pkg::item_t           in_item_d, in_item_q;
  logic [ctsc_pkg::DayW-1:0] in_day_d, in_day_q;
  logic                      in_valid_q;
  ctsc_pkg::hms_t            hms;
  ctsc_pkg::result_t         result;
  ctsc_pkg::result_t         out_q;
  logic                      out_valid_q;
  logic                      advance;
  logic                      step;

  assign in_item_d.tick_ms    = s_axis_tdata[31:0];
  assign in_item_d.time_count = s_axis_tdata[63:32];
  assign in_item_d.press_set  = s_axis_tdata[64];
  assign in_item_d.press_up   = s_axis_tdata[65];
  assign in_item_d.press_down = s_axis_tdata[66];

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  ctsc_day_rem u_day_rem (
    .count_i   (in_item_d.time_count),
    .day_rem_o (in_day_d)
  );

  ctsc_hms_split u_hms_split (
    .day_rem_i (in_day_q),
    .hms_o     (hms)
  );

  ctsc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .hms_i     (hms),
    .timeout_i (timeout_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ctsc_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
      in_day_q  <= in_day_d;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.write_seconds, out_q.write_valid,
                          out_q.cursor_field, out_q.show_second, out_q.show_minute,
                          out_q.show_hour, out_q.show_valid, out_q.setup_mode};

endmodule

// ===== src/ctsc_checker.sv =====
// ----------------------------------------------------------------------------
// ctsc_checker
// Port-level checks on the result stream of the time-set controller.
// ----------------------------------------------------------------------------
module ctsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic                 setup_mode;
  logic                 show_valid;
  logic [4:0]           show_hour;
  logic [5:0]           show_minute;
  logic [5:0]           show_second;
  logic [1:0]           cursor_field;
  logic                 write_valid;
  logic [16:0]          write_seconds;

  assign setup_mode    = m_axis_tdata[0];
  assign show_valid    = m_axis_tdata[1];
  assign show_hour     = m_axis_tdata[6:2];
  assign show_minute   = m_axis_tdata[12:7];
  assign show_second   = m_axis_tdata[18:13];
  assign cursor_field  = m_axis_tdata[20:19];
  assign write_valid   = m_axis_tdata[21];
  assign write_seconds = m_axis_tdata[38:22];

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // display fields are zero without a refresh, and in range with one
  a_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (show_valid ? (show_hour <= 5'd23 && show_minute <= 6'd59 &&
                                     show_second <= 6'd59)
                                  : (m_axis_tdata[20:2] == '0)))
    else $error("display fields inconsistent with show_valid");

  // a write comes only from setup, alone and in range
  a_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && write_valid |-> setup_mode && !show_valid &&
                                     write_seconds <= 17'd86340)
    else $error("bad time write beat");

  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !write_valid |-> write_seconds == '0)
    else $error("write_seconds set without write_valid");

  // a cursor belongs to a setup refresh with zero seconds
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cursor_field != 2'd0 |-> setup_mode && show_valid &&
                                              show_second == '0 && cursor_field != 2'd3)
    else $error("cursor outside setup refresh");

endmodule

bind clock_time_set_controller ctsc_checker u_ctsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
